/* rtl/core/tptzfr_pkg.sv */
// Shared widths, limits and handshake structures for the two-pole two-zero
// frequency regulator. No dependencies; used by tptzfr_mul and the top level.

package tptzfr_pkg;

	localparam int COEF_W     = 24;   // Q12.12 coefficients
	localparam int STATE_W    = 40;   // filter states, Hz with 12 fractional bits
	localparam int PROD_W     = 64;   // full coefficient-by-state product
	localparam int MUL_DIGITS = COEF_W / 2;   // radix-4 Booth digits per product
	localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
	localparam int FREQ_W     = 20;

	localparam logic [FREQ_W-1:0] FREQ_MIN = 20'd60000;
	localparam logic [FREQ_W-1:0] FREQ_MAX = 20'd300000;

	// Request to the serial multiplier: load operands and start.
	typedef struct packed {
		logic                       start;
		logic signed [COEF_W-1:0]   coef;
		logic signed [STATE_W-1:0]  mcand;
	} mul_req_t;

	// Response: done pulses for one cycle while the product is valid.
	typedef struct packed {
		logic                       done;
		logic signed [PROD_W-1:0]   product;
	} mul_rsp_t;

endpackage

/* rtl/core/tptzfr_mul.sv */
// Digit-serial signed multiplier, radix-4 Booth, most significant digit first.
// Depends on tptzfr_pkg for widths and the request/response structures.

module tptzfr_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tptzfr_pkg::mul_req_t req,
	output tptzfr_pkg::mul_rsp_t rsp
);

	logic                                   busy_q;
	logic                                   done_q;
	logic [tptzfr_pkg::MUL_CNT_W-1:0]       cnt_q;
	logic [tptzfr_pkg::COEF_W:0]            rec_q;
	logic signed [tptzfr_pkg::STATE_W-1:0]  x_q;
	logic signed [tptzfr_pkg::PROD_W-1:0]   acc_q;
	logic signed [tptzfr_pkg::PROD_W-1:0]   x_ext;
	logic signed [tptzfr_pkg::PROD_W-1:0]   part;
	logic signed [tptzfr_pkg::PROD_W-1:0]   acc_next;

	assign x_ext = {{(tptzfr_pkg::PROD_W - tptzfr_pkg::STATE_W){x_q[tptzfr_pkg::STATE_W-1]}},
		x_q};

	// The top three bits of the recoding register form the current Booth digit.
	always_comb begin
		unique case (rec_q[tptzfr_pkg::COEF_W -: 3])
			3'b001, 3'b010: part = x_ext;
			3'b011:         part = x_ext <<< 1;
			3'b100:         part = -(x_ext <<< 1);
			3'b101, 3'b110: part = -x_ext;
			default:        part = '0;
		endcase
		acc_next = (acc_q <<< 2) + part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tptzfr_pkg::MUL_CNT_W'(tptzfr_pkg::MUL_DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			rec_q <= {req.coef, 1'b0};
			x_q   <= req.mcand;
		end else if (busy_q) begin
			acc_q <= acc_next;
			rec_q <= rec_q << 2;
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

/* rtl/core/two_pole_two_zero_freq_regulator.sv */
// Top level of the two-pole two-zero frequency regulator: configuration
// registers, sequencer, filter states and output register. Uses tptzfr_pkg, tptzfr_mul.

// Each beat on the input stream carries one voltage and one current sample and
// the loop enable flag; each produces exactly one beat on the output stream with
// the commanded switching frequency and the loop status. In closed loop the
// error (voltage target minus sample) runs through a transposed direct-form-II
// filter with two 40-bit saturating states, and the command is the nominal
// frequency plus the filter output, rounded to whole Hz and clamped to
// FREQ_MIN..FREQ_MAX. All five coefficient products go through one shared
// radix-4 serial multiplier that retires two coefficient bits per cycle; a
// closed-loop item runs through the five products and then the rounding,
// clamping and output states before its result is presented. An item in
// open loop, or with the overcurrent fault latched, goes straight to output. The input
// is taken again as soon as the sequencer is idle, even while the previous
// result still waits in the output register. Once an overcurrent has been seen
// in closed loop the fault stays latched until reset; open-loop items still
// return the nominal frequency meanwhile. Configuration writes are always
// accepted and should only be issued while the block is idle.

module two_pole_two_zero_freq_regulator (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// Sample stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [11:0] volt_sample, [23:12] current_sample
	input  logic        s_tuser,  // [0] loop_enable
	// Command stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [19:0] freq_command, [21:20] loop_status, rest zero
);

	localparam int ERR_W  = 13;
	localparam int TRIM_W = 52;   // rounded coefficient-by-w term
	localparam int SUM_W  = 42;   // nominal frequency plus w before rounding
	localparam int RAW_W  = SUM_W - 12;

	localparam logic [3:0] REG_B0      = 4'd0;
	localparam logic [3:0] REG_B1      = 4'd1;
	localparam logic [3:0] REG_B2      = 4'd2;
	localparam logic [3:0] REG_A1      = 4'd3;
	localparam logic [3:0] REG_A2      = 4'd4;
	localparam logic [3:0] REG_TARGET  = 4'd5;
	localparam logic [3:0] REG_LIMIT   = 4'd6;
	localparam logic [3:0] REG_NOMINAL = 4'd7;

	localparam logic signed [tptzfr_pkg::PROD_W-1:0] ST_MAX_EXT = 64'sh0000_007F_FFFF_FFFF;
	localparam logic signed [tptzfr_pkg::PROD_W-1:0] ST_MIN_EXT = -ST_MAX_EXT - 64'sd1;
	localparam logic signed [RAW_W-1:0] RAW_MIN = RAW_W'(tptzfr_pkg::FREQ_MIN);
	localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'(tptzfr_pkg::FREQ_MAX);

	typedef enum logic [1:0] {
		LS_OPEN,
		LS_REGULATING,
		LS_CLAMPED,
		LS_FAULT
	} loop_status_t;

	// Each multiply state waits for one product and folds it in; all but ST_MUL_B2 also launch the next.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_B0,
		ST_MUL_A1,
		ST_MUL_B1,
		ST_MUL_A2,
		ST_MUL_B2,
		ST_ROUND,
		ST_CLAMP,
		ST_OUT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic signed [tptzfr_pkg::COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [11:0]                          target_q;
	logic [11:0]                          limit_q;
	logic [tptzfr_pkg::FREQ_W-1:0]        nominal_q;

	// Filter state and fault latch
	logic signed [tptzfr_pkg::STATE_W-1:0] s1_q, s2_q;
	logic                                  fault_q;

	// Per-item working registers
	logic signed [ERR_W-1:0]                err_q;
	logic signed [tptzfr_pkg::STATE_W-1:0]  w_q;
	logic signed [TRIM_W-1:0]               trim_q;
	logic signed [RAW_W-1:0]                raw_q;
	logic [tptzfr_pkg::FREQ_W-1:0]          res_freq_q;
	loop_status_t                           res_status_q;
	logic                                   m_tvalid_q;
	logic [23:0]                            m_tdata_q;

	tptzfr_pkg::mul_req_t mul_req;
	tptzfr_pkg::mul_rsp_t mul_rsp;

	logic                                   accept;
	logic                                   trip;
	logic                                   run_in;
	logic                                   out_free;
	logic signed [ERR_W-1:0]                err_in;
	logic signed [tptzfr_pkg::PROD_W-1:0]   rnd_full;
	logic signed [tptzfr_pkg::STATE_W-1:0]  w_new;
	logic signed [tptzfr_pkg::STATE_W-1:0]  s1_new;
	logic signed [tptzfr_pkg::STATE_W-1:0]  s2_new;
	logic signed [SUM_W-1:0]                sum_full;
	logic signed [RAW_W-1:0]                clamp_freq;
	loop_status_t                           clamp_status;

	function automatic logic signed [tptzfr_pkg::PROD_W-1:0] ext_state(
		input logic signed [tptzfr_pkg::STATE_W-1:0] v);
		return {{(tptzfr_pkg::PROD_W - tptzfr_pkg::STATE_W){v[tptzfr_pkg::STATE_W-1]}}, v};
	endfunction

	function automatic logic signed [tptzfr_pkg::STATE_W-1:0] ext_err(
		input logic signed [ERR_W-1:0] v);
		return {{(tptzfr_pkg::STATE_W - ERR_W){v[ERR_W-1]}}, v};
	endfunction

	function automatic logic signed [tptzfr_pkg::PROD_W-1:0] ext_trim(
		input logic signed [TRIM_W-1:0] v);
		return {{(tptzfr_pkg::PROD_W - TRIM_W){v[TRIM_W-1]}}, v};
	endfunction

	// Saturate a wide sum to the signed state range.
	function automatic logic signed [tptzfr_pkg::STATE_W-1:0] sat_state(
		input logic signed [tptzfr_pkg::PROD_W-1:0] v);
		logic signed [tptzfr_pkg::STATE_W-1:0] r;
		if (v > ST_MAX_EXT) begin
			r = ST_MAX_EXT[tptzfr_pkg::STATE_W-1:0];
		end else if (v < ST_MIN_EXT) begin
			r = ST_MIN_EXT[tptzfr_pkg::STATE_W-1:0];
		end else begin
			r = v[tptzfr_pkg::STATE_W-1:0];
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign accept   = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign err_in   = $signed({1'b0, target_q}) - $signed({1'b0, s_tdata[11:0]});
	// An overcurrent only counts while the loop is enabled.
	assign trip     = fault_q || (s_tdata[23:12] > limit_q);
	assign run_in   = s_tuser && !trip;

	// Folding each finished product into the filter. The a-terms carry 24
	// fractional bits and are rounded to nearest, ties upwards, before use.
	always_comb begin
		rnd_full = (mul_rsp.product + 64'sd2048) >>> 12;
		w_new    = sat_state(mul_rsp.product + ext_state(s1_q));
		s1_new   = sat_state(mul_rsp.product - ext_trim(trim_q) + ext_state(s2_q));
		s2_new   = sat_state(mul_rsp.product - ext_trim(trim_q));
		sum_full = $signed({{(SUM_W - tptzfr_pkg::FREQ_W - 12){1'b0}}, nominal_q, 12'd0})
			+ {{(SUM_W - tptzfr_pkg::STATE_W){w_q[tptzfr_pkg::STATE_W-1]}}, w_q}
			+ SUM_W'(2048);
	end

	// Multiplier launch: the first product starts on acceptance, the rest start
	// in the cycle that retires the previous one.
	always_comb begin
		mul_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_req.start = accept && run_in;
				mul_req.coef  = b0_q;
				mul_req.mcand = ext_err(err_in);
			end
			ST_MUL_B0: begin
				mul_req.start = mul_rsp.done;
				mul_req.coef  = a1_q;
				mul_req.mcand = w_new;
			end
			ST_MUL_A1: begin
				mul_req.start = mul_rsp.done;
				mul_req.coef  = b1_q;
				mul_req.mcand = ext_err(err_q);
			end
			ST_MUL_B1: begin
				mul_req.start = mul_rsp.done;
				mul_req.coef  = a2_q;
				mul_req.mcand = w_q;
			end
			ST_MUL_A2: begin
				mul_req.start = mul_rsp.done;
				mul_req.coef  = b2_q;
				mul_req.mcand = ext_err(err_q);
			end
			default: mul_req = '0;
		endcase
	end

	// The low bound is applied first, then the high bound, so the high bound
	// wins should the two ever cross.
	always_comb begin
		clamp_freq   = raw_q;
		clamp_status = LS_REGULATING;
		if (raw_q < RAW_MIN) begin
			clamp_freq   = RAW_MIN;
			clamp_status = LS_CLAMPED;
		end
		if (clamp_freq > RAW_MAX) begin
			clamp_freq   = RAW_MAX;
			clamp_status = LS_CLAMPED;
		end
	end

	tptzfr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Sequencer, configuration, filter state and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			b0_q       <= '0;
			b1_q       <= '0;
			b2_q       <= '0;
			a1_q       <= '0;
			a2_q       <= '0;
			target_q   <= 12'd2048;
			limit_q    <= 12'd4095;
			nominal_q  <= 20'd100000;
			s1_q       <= '0;
			s2_q       <= '0;
			fault_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_B0:      b0_q      <= cfg_data;
					REG_B1:      b1_q      <= cfg_data;
					REG_B2:      b2_q      <= cfg_data;
					REG_A1:      a1_q      <= cfg_data;
					REG_A2:      a2_q      <= cfg_data;
					REG_TARGET:  target_q  <= cfg_data[11:0];
					REG_LIMIT:   limit_q   <= cfg_data[11:0];
					REG_NOMINAL: nominal_q <= cfg_data[tptzfr_pkg::FREQ_W-1:0];
					default: ;
				endcase
			end

			// A new result is presented once the output register is free;
			// otherwise a taken beat empties it.
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!s_tuser) begin
							s1_q    <= '0;
							s2_q    <= '0;
							state_q <= ST_OUT;
						end else if (trip) begin
							fault_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MUL_B0;
						end
					end
				end
				ST_MUL_B0: if (mul_rsp.done) state_q <= ST_MUL_A1;
				ST_MUL_A1: if (mul_rsp.done) state_q <= ST_MUL_B1;
				ST_MUL_B1: begin
					if (mul_rsp.done) begin
						s1_q    <= s1_new;
						state_q <= ST_MUL_A2;
					end
				end
				ST_MUL_A2: if (mul_rsp.done) state_q <= ST_MUL_B2;
				ST_MUL_B2: begin
					if (mul_rsp.done) begin
						s2_q    <= s2_new;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers that need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= err_in;
			if (!s_tuser) begin
				res_freq_q   <= nominal_q;
				res_status_q <= LS_OPEN;
			end else begin
				res_freq_q   <= tptzfr_pkg::FREQ_MIN;
				res_status_q <= LS_FAULT;
			end
		end
		if (state_q == ST_MUL_B0 && mul_rsp.done) begin
			w_q <= w_new;
		end
		if ((state_q == ST_MUL_A1 || state_q == ST_MUL_A2) && mul_rsp.done) begin
			trim_q <= rnd_full[TRIM_W-1:0];
		end
		if (state_q == ST_ROUND) begin
			raw_q <= sum_full[SUM_W-1:12];
		end
		if (state_q == ST_CLAMP) begin
			res_freq_q   <= clamp_freq[tptzfr_pkg::FREQ_W-1:0];
			res_status_q <= clamp_status;
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {2'b00, res_status_q, res_freq_q};
		end
	end

endmodule

/* sim/two_pole_two_zero_freq_regulator_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the two-pole two-zero frequency regulator: random and
// directed sample beats, a bit-exact filter predictor held in a scoreboard class.
// Depends on tptzfr_pkg and the regulator RTL only.

module two_pole_two_zero_freq_regulator_tb;

	import tptzfr_pkg::*;

	// A generous ceiling on the whole run: roughly 1500 samples plus idling and
	// drains stay far below it.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 120;
	localparam int FAULT_ITEMS = 60;
	localparam int REPORT_LIMIT = 10;
	localparam int SETTLE_CYCLES = 80;

	localparam longint STATE_MAX = (longint'(1) << (STATE_W - 1)) - 1;
	localparam longint STATE_MIN = -STATE_MAX - 1;

	typedef enum logic [3:0] {
		REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_TARGET, REG_OC_LIMIT, REG_NOMINAL
	} reg_index_e;

	typedef enum logic [1:0] {
		LOOP_OPEN, LOOP_REGULATING, LOOP_CLAMPED, LOOP_FAULT
	} loop_status_e;

	typedef enum int {
		SET_RANDOM, SET_GENTLE, SET_ALL_MAX, SET_ALL_MIN, SET_KINDS
	} setting_e;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [1:0]        status;
	} command_t;

	// The scoreboard keeps its own copy of the registers and the two filter
	// states. Every accepted sample beat is modelled at once and
	// the command it must produce is queued; command beats are checked in order.
	class command_tracker;
		longint      b0, b1, b2, a1, a2;
		int unsigned target, oc_limit, nominal;
		longint      state_one, state_two;
		bit          fault;
		command_t    expected_q[$];
		int unsigned mismatches, checked, samples, writes, ignored_writes;

		function new();
			b0 = 0; b1 = 0; b2 = 0; a1 = 0; a2 = 0;
			target = 2048;
			oc_limit = 4095;
			nominal = 100000;
			state_one = 0;
			state_two = 0;
			fault = 1'b0;
			mismatches = 0; checked = 0; samples = 0; writes = 0; ignored_writes = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function longint widen_coef(logic [23:0] raw);
			logic signed [COEF_W-1:0] c;
			c = raw;
			return longint'(c);
		endfunction

		function longint clip_state(longint v);
			if (v > STATE_MAX) return STATE_MAX;
			if (v < STATE_MIN) return STATE_MIN;
			return v;
		endfunction

		// Q12.12 coefficient times a Q.12 value, back to Q.12 rounding half up.
		function longint scaled_product(longint c, longint x);
			return (c * x + 2048) >>> 12;
		endfunction

		function void mirror_register(logic [3:0] idx, logic [23:0] value);
			writes++;
			case (idx)
			REG_B0:       b0 = widen_coef(value);
			REG_B1:       b1 = widen_coef(value);
			REG_B2:       b2 = widen_coef(value);
			REG_A1:       a1 = widen_coef(value);
			REG_A2:       a2 = widen_coef(value);
			REG_TARGET:   target = value[11:0];
			REG_OC_LIMIT: oc_limit = value[11:0];
			REG_NOMINAL:  nominal = value[FREQ_W-1:0];
			default:      ignored_writes++;
			endcase
		endfunction

		function void note_sample(logic [11:0] volt, logic [11:0] cur, logic en);
			command_t cmd;
			longint   err, w, s1, s2, rounded;
			samples++;
			if (!en) begin
				// Open loop clears both states but keeps any latched fault.
				state_one = 0;
				state_two = 0;
				cmd.freq = nominal[FREQ_W-1:0];
				cmd.status = LOOP_OPEN;
			end else begin
				if (cur > oc_limit)
					fault = 1'b1;
				if (fault) begin
					cmd.freq = FREQ_MIN;
					cmd.status = LOOP_FAULT;
				end else begin
					err = longint'(target) - longint'(volt);
					w = clip_state(b0 * err + state_one);
					s1 = clip_state(b1 * err - scaled_product(a1, w) + state_two);
					s2 = clip_state(b2 * err - scaled_product(a2, w));
					state_one = s1;
					state_two = s2;
					rounded = (longint'(nominal) * 4096 + w + 2048) >>> 12;
					cmd.status = LOOP_REGULATING;
					if (rounded < longint'(FREQ_MIN)) begin
						rounded = longint'(FREQ_MIN);
						cmd.status = LOOP_CLAMPED;
					end
					if (rounded > longint'(FREQ_MAX)) begin
						rounded = longint'(FREQ_MAX);
						cmd.status = LOOP_CLAMPED;
					end
					cmd.freq = rounded[FREQ_W-1:0];
				end
			end
			expected_q.push_back(cmd);
		endfunction

		function void check_command(logic [23:0] beat);
			command_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: command beat %h arrived with nothing outstanding", $time, beat);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (beat[FREQ_W-1:0] !== want.freq || beat[21:20] !== want.status
					|| beat[23:22] !== 2'b00) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: command %0d: freq expected %0d got %0d, status expected %0d got %0d, pad %b",
						$time, checked, want.freq, beat[FREQ_W-1:0], want.status,
						beat[21:20], beat[23:22]);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // [11:0] volt_sample, [23:12] current_sample
	logic        s_tuser = 1'b0;  // [0] loop_enable
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;  // [19:0] freq_command, [21:20] loop_status, [23:22] zero

	// Percentage of cycles in which the sender holds back and the receiver stalls.
	int src_idle = 32;
	int sink_idle = 60;
	int setting_count = 0;

	command_tracker tracker;

	two_pole_two_zero_freq_regulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver decides afresh at every falling edge whether it will take a beat.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle);
	end

	// All handshakes are observed at the rising edge, in one place, so that the
	// register mirror, the predictor and the checker see the beats in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.mirror_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				tracker.note_sample(s_tdata[11:0], s_tdata[23:12], s_tuser);
			if (m_tvalid && m_tready)
				tracker.check_command(m_tdata);
		end
	end

	// Offers one sample beat and returns at the falling edge after it was taken,
	// with tvalid left high so that back-to-back beats need no second assignment.
	// Now and then the sender sits out a long gap so that the next beat lands on
	// an arbitrary point of the block's multiply sequence.
	task automatic send_sample(input logic [11:0] volt, input logic [11:0] cur,
			input logic en);
		int gap;
		gap = 0;
		if (src_idle != 0) begin
			if ($urandom_range(99) < 4)
				gap = $urandom_range(90, 1);
			else
				while ($urandom_range(99) < src_idle) gap++;
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cur, volt};
		s_tuser <= en;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic load_register(input logic [3:0] idx, input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stops offering samples and waits until every queued command has come back,
	// plus a few cycles so that the sequencer is certainly at rest.
	task automatic wait_until_idle();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [23:0] gentle_coef(input int span);
		int v;
		v = int'($urandom_range(2 * span)) - span;
		return v[23:0];
	endfunction

	// Writes a complete register set of the chosen kind, then a write to an index
	// the block must ignore.
	task automatic configure(input setting_e kind);
		case (kind)
		SET_RANDOM: begin
			load_register(REG_B0, 24'($urandom()));
			load_register(REG_B1, 24'($urandom()));
			load_register(REG_B2, 24'($urandom()));
			load_register(REG_A1, 24'($urandom()));
			load_register(REG_A2, 24'($urandom()));
			load_register(REG_TARGET, 24'($urandom()));
			load_register(REG_OC_LIMIT, 24'($urandom()));
			load_register(REG_NOMINAL, 24'($urandom()));
		end
		SET_GENTLE: begin
			load_register(REG_B0, gentle_coef(262144));
			load_register(REG_B1, gentle_coef(262144));
			load_register(REG_B2, gentle_coef(131072));
			load_register(REG_A1, gentle_coef(8192));
			load_register(REG_A2, gentle_coef(4096));
			load_register(REG_TARGET, 24'($urandom_range(4095)));
			load_register(REG_OC_LIMIT, 24'($urandom_range(4095)));
			load_register(REG_NOMINAL, 24'($urandom_range(350000, 40000)));
		end
		SET_ALL_MAX: begin
			load_register(REG_B0, 24'h7FFFFF);
			load_register(REG_B1, 24'h7FFFFF);
			load_register(REG_B2, 24'h7FFFFF);
			load_register(REG_A1, 24'h7FFFFF);
			load_register(REG_A2, 24'h7FFFFF);
			load_register(REG_TARGET, 24'hFFFFFF);
			load_register(REG_OC_LIMIT, 24'hFFFFFF);
			load_register(REG_NOMINAL, 24'hFFFFFF);
		end
		default: begin
			load_register(REG_B0, 24'h800000);
			load_register(REG_B1, 24'h800000);
			load_register(REG_B2, 24'h800000);
			load_register(REG_A1, 24'h800000);
			load_register(REG_A2, 24'h800000);
			load_register(REG_TARGET, 24'h000000);
			load_register(REG_OC_LIMIT, 24'h000000);
			load_register(REG_NOMINAL, 24'h000000);
		end
		endcase
		load_register(4'($urandom_range(15, int'(REG_NOMINAL) + 1)), 24'($urandom()));
		setting_count++;
	endtask

	// Mostly closed-loop beats whose current stays within the limit, so that the
	// filter keeps running; open-loop beats carry any current at all. With
	// unrestricted set, closed-loop beats may trip the fault latch as well.
	task automatic random_sample(input bit unrestricted);
		logic [11:0] volt, cur;
		logic        en;
		int          near;
		en = ($urandom_range(9) != 0);
		case ($urandom_range(7))
		0: volt = '0;
		1: volt = '1;
		2: begin
			near = int'(tracker.target) + int'($urandom_range(32)) - 16;
			if (near < 0) near = 0;
			if (near > 4095) near = 4095;
			volt = near[11:0];
		end
		default: volt = 12'($urandom());
		endcase
		if (en && !unrestricted)
			cur = 12'($urandom_range(tracker.oc_limit));
		else if ($urandom_range(3) == 0)
			cur = '1;
		else
			cur = 12'($urandom());
		send_sample(volt, cur, en);
	endtask

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Run stopped after %0d cycles with %0d commands outstanding",
			CYCLE_LIMIT, tracker.pending());
		$display("** two_pole_two_zero_freq_regulator: FAILED **");
		$finish;
	end

	initial begin
		tracker = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// With the reset register values the filter output is zero, so a closed
		// loop beat returns the nominal frequency unclamped.
		send_sample(12'd2048, 12'd0, 1'b1);
		send_sample(12'hFFF, 12'hFFF, 1'b0);
		wait_until_idle();

		// A hand-picked stable filter: 100 Hz per LSB proportional path.
		load_register(REG_B0, 24'sd409600);
		load_register(REG_B1, -24'sd204800);
		load_register(REG_B2, 24'sd40960);
		load_register(REG_A1, -24'sd6144);
		load_register(REG_A2, 24'sd2304);
		load_register(REG_TARGET, 24'd2000);
		load_register(REG_OC_LIMIT, 24'd3000);
		load_register(REG_NOMINAL, 24'd150000);
		setting_count++;
		send_sample(12'd2000, 12'd3000, 1'b1);  // current equal to the limit: no trip
		send_sample(12'd0, 12'd100, 1'b1);      // large positive error: upper clamp
		send_sample(12'hFFF, 12'd100, 1'b1);    // large negative error, offset by the filter state: unclamped
		send_sample(12'd1990, 12'd0, 1'b1);
		send_sample(12'd0, 12'hFFF, 1'b0);      // overcurrent in open loop is ignored
		send_sample(12'd1990, 12'd0, 1'b1);     // states start again from zero
		send_sample(12'd2010, 12'd0, 1'b1);
		send_sample(12'd2000, 12'd0, 1'b1);
		wait_until_idle();

		// Half a hertz per LSB: odd errors give the proportional term a half-hertz fraction.
		load_register(REG_B0, 24'sd2048);
		send_sample(12'd1999, 12'd0, 1'b1);
		send_sample(12'd2001, 12'd0, 1'b1);
		send_sample(12'd1997, 12'd0, 1'b1);
		send_sample(12'd2003, 12'd0, 1'b1);
		send_sample(12'd2000, 12'd0, 1'b0);

		// Three idling regimes, each over all kinds of register setting. Every
		// phase change drains the block first, which also pauses the sender until
		// every outstanding command has come back.
		for (int regime = 0; regime < 3; regime++) begin
			src_idle = (regime == 0) ? 32 : (regime == 1) ? 60 : 0;
			sink_idle = (regime == 0) ? 60 : (regime == 1) ? 32 : 0;
			for (int kind = 0; kind < int'(SET_KINDS); kind++) begin
				wait_until_idle();
				configure(setting_e'(kind));
				repeat (PHASE_ITEMS) random_sample(1'b0);
			end
		end

		// The fault latch is only cleared by reset, so it is exercised last.
		wait_until_idle();
		configure(SET_GENTLE);
		load_register(REG_OC_LIMIT, 24'd1000);
		send_sample(12'd1000, 12'd1000, 1'b1);  // at the limit: still regulating
		send_sample(12'd1000, 12'hFFF, 1'b0);   // open loop never trips
		send_sample(12'd1000, 12'd1001, 1'b1);  // trips in this very beat
		send_sample(12'd1000, 12'd0, 1'b1);     // stays latched with low current
		send_sample(12'd1000, 12'd0, 1'b0);     // open loop still gives nominal
		send_sample(12'd0, 12'd0, 1'b1);
		wait_until_idle();
		load_register(REG_NOMINAL, 24'd77777);
		repeat (FAULT_ITEMS) random_sample(1'b1);

		wait_until_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d sample beats over %0d register settings; %0d commands checked.",
			tracker.samples, setting_count, tracker.checked);
		$display("Register writes %0d (%0d to unused indexes), failures %0d.",
			tracker.writes, tracker.ignored_writes, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("** two_pole_two_zero_freq_regulator: PASSED **");
		end else begin
			$display("** two_pole_two_zero_freq_regulator: FAILED **");
		end
		$finish;
	end

endmodule
